// ===== sv/cnmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnmt_pkg
// Shared types, constants and calendar helpers for the cron next-match block.
// ----------------------------------------------------------------------------
package cnmt_pkg;

	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [11:0] EPOCH_YEAR  = 12'd1970;
	localparam logic [2:0]  EPOCH_WDAY  = 3'd4;        // 1970-01-01 was a Thursday
	localparam logic [30:0] ALL_DAYS    = 31'h7FFF_FFFF;
	localparam int          CFG_DW      = 60;
	// ceil(2^35 / 675); exact quotient for any 25-bit dividend
	localparam logic [25:0] DAY_RECIP   = 26'd50903317;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SECOND  = 3'd0,
		REG_MINUTE  = 3'd1,
		REG_HOUR    = 3'd2,
		REG_DAY     = 3'd3,
		REG_MONTH   = 3'd4,
		REG_WEEKDAY = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_HMS,
		ST_YMD,
		ST_STEP,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic div_en;
		logic hms_en;
		logic ymd_en;
		logic step_en;
		logic wr_res;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_last;
		logic hms_done;
		logic ymd_done;
		logic step_fin;
	} sts_t;

	// leap years in 1970..2107: divisible by 4, except 2100
	function automatic logic is_leap(input logic [11:0] y);
		is_leap = (y[1:0] == 2'd0) && (y != 12'd2100);
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
		unique case (m)
			4'd2:                     days_in_month = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  days_in_month = 5'd30;
			default:                  days_in_month = 5'd31;
		endcase
	endfunction

	// residue mod 7 of a 6-bit value by fixed compare-subtract steps
	function automatic logic [2:0] mod7(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		if (r >= 6'd56) r = r - 6'd56;
		if (r >= 6'd28) r = r - 6'd28;
		if (r >= 6'd14) r = r - 6'd14;
		if (r >= 6'd7)  r = r - 6'd7;
		mod7 = r[2:0];
	endfunction

endpackage

// ===== sv/cnmt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnmt_ctrl
// Sequencer: split time, decompose, step the search, hand off the result.
// ----------------------------------------------------------------------------
module cnmt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  cnmt_pkg::sts_t sts,
	output cnmt_pkg::cmd_t cmd
);
	import cnmt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIV;
			ST_DIV:  if (sts.div_last) state_d = ST_HMS;
			ST_HMS:  if (sts.hms_done) state_d = ST_YMD;
			ST_YMD:  if (sts.ymd_done) state_d = ST_STEP;
			ST_STEP: if (sts.step_fin) state_d = ST_DONE;
			ST_DONE: if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV:  cmd.div_en  = 1'b1;
			ST_HMS:  cmd.hms_en  = 1'b1;
			ST_YMD:  cmd.ymd_en  = 1'b1;
			ST_STEP: cmd.step_en = 1'b1;
			ST_DONE: cmd.wr_res  = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.wr_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/cnmt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnmt_dp
// Datapath: mask registers, time split, calendar state and search step.
// ----------------------------------------------------------------------------
module cnmt_dp #(
	parameter int MAX_STEPS = 65535
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [cnmt_pkg::CFG_DW-1:0] cfg_data,
	input  logic [31:0]                start_time,
	input  cnmt_pkg::cmd_t             cmd,
	output cnmt_pkg::sts_t             sts,
	output logic                       found,
	output logic [31:0]                next_time
);
	import cnmt_pkg::*;

	localparam int SW = $clog2(MAX_STEPS);

	// mask registers
	logic [59:0] sec_mask_q, min_mask_q;
	logic [23:0] hour_mask_q;
	logic [30:0] day_mask_q;
	logic [11:0] month_mask_q;
	logic [6:0]  wday_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_mask_q   <= '1;
			min_mask_q   <= '1;
			hour_mask_q  <= '1;
			day_mask_q   <= '1;
			month_mask_q <= '1;
			wday_mask_q  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SECOND:  sec_mask_q   <= cfg_data[59:0];
				REG_MINUTE:  min_mask_q   <= cfg_data[59:0];
				REG_HOUR:    hour_mask_q  <= cfg_data[23:0];
				REG_DAY:     day_mask_q   <= cfg_data[30:0];
				REG_MONTH:   month_mask_q <= cfg_data[11:0];
				REG_WEEKDAY: wday_mask_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// search state
	logic [32:0]   t_q;
	logic [16:0]   rem_q;
	logic [15:0]   quo_q;
	logic          cnt_q;
	logic [16:0]   sod_q;
	logic [4:0]    hh_q;
	logic [5:0]    mi_q, ss_q;
	logic [11:0]   y_q;
	logic [3:0]    m_q;
	logic [4:0]    d_q;
	logic [2:0]    wd_q;
	logic [SW-1:0] step_q;
	logic          found_q, ovf_q;
	logic          res_found_q;
	logic [31:0]   res_time_q;

	// day split: shift out the factor 128, reciprocal multiply by 1/675;
	// remainder and weekday follow in the cycle after the quotient
	logic [50:0] recip_prod;
	logic [32:0] day_secs;
	logic [16:0] sod_split;
	logic [5:0]  oct_sum;
	assign recip_prod = 51'(t_q[31:7]) * 51'(DAY_RECIP);
	assign day_secs   = 33'(quo_q) * 33'(SEC_PER_DAY);
	assign sod_split  = 17'(t_q - day_secs);
	// 8 is 1 mod 7, so the octal digits of the day count sum to its residue
	assign oct_sum    = 6'(quo_q[2:0]) + 6'(quo_q[5:3]) + 6'(quo_q[8:6])
	                  + 6'(quo_q[11:9]) + 6'(quo_q[14:12]) + 6'(quo_q[15])
	                  + 6'(EPOCH_WDAY);

	// calendar lengths
	logic       leap;
	logic [4:0] dim;
	logic [8:0] ylen;
	assign leap = is_leap(y_q);
	assign dim  = days_in_month(m_q, leap);
	assign ylen = leap ? 9'd366 : 9'd365;

	// next-day values
	logic        last_day;
	logic [4:0]  nd_d;
	logic [3:0]  nd_m;
	logic [11:0] nd_y;
	logic [2:0]  nd_wd;
	assign last_day = d_q == dim;
	assign nd_d     = last_day ? 5'd1 : 5'(d_q + 5'd1);
	assign nd_m     = !last_day ? m_q : (m_q == 4'd12 ? 4'd1 : 4'(m_q + 4'd1));
	assign nd_y     = (last_day && m_q == 4'd12) ? 12'(y_q + 12'd1) : y_q;
	assign nd_wd    = (wd_q == 3'd6) ? 3'd0 : 3'(wd_q + 3'd1);

	// field tests
	logic month_ok, day_ok, hour_ok, min_ok, sec_ok;
	assign month_ok = month_mask_q[4'(m_q - 4'd1)];
	assign day_ok   = (day_mask_q == ALL_DAYS) ? wday_mask_q[wd_q]
	                                           : day_mask_q[5'(d_q - 5'd1)];
	assign hour_ok  = hour_mask_q[hh_q];
	assign min_ok   = min_mask_q[mi_q];
	assign sec_ok   = sec_mask_q[ss_q];

	// one search step
	logic [4:0]  skip;
	logic [32:0] day_start, t_n;
	logic [16:0] sod_n;
	logic [4:0]  hh_n, d_n;
	logic [5:0]  mi_n, ss_n;
	logic [3:0]  m_n;
	logic [11:0] y_n;
	logic [2:0]  wd_n;
	logic        hit, step_last;

	assign skip      = 5'(dim - d_q + 5'd1);
	assign day_start = t_q - 33'(sod_q);
	assign step_last = step_q == SW'(MAX_STEPS - 2);

	always_comb begin
		t_n   = t_q;
		sod_n = sod_q;
		hh_n  = hh_q;
		mi_n  = mi_q;
		ss_n  = ss_q;
		d_n   = d_q;
		m_n   = m_q;
		y_n   = y_q;
		wd_n  = wd_q;
		hit   = 1'b0;
		priority if (!month_ok) begin
			t_n   = day_start + 33'(skip) * 33'(SEC_PER_DAY);
			sod_n = '0; hh_n = '0; mi_n = '0; ss_n = '0;
			d_n   = 5'd1;
			m_n   = (m_q == 4'd12) ? 4'd1 : 4'(m_q + 4'd1);
			y_n   = (m_q == 4'd12) ? 12'(y_q + 12'd1) : y_q;
			wd_n  = mod7(6'(wd_q) + 6'(skip));
		end else if (!day_ok) begin
			t_n   = day_start + 33'(SEC_PER_DAY);
			sod_n = '0; hh_n = '0; mi_n = '0; ss_n = '0;
			d_n = nd_d; m_n = nd_m; y_n = nd_y; wd_n = nd_wd;
		end else if (!hour_ok) begin
			t_n   = t_q + 33'd3600 - 33'(mi_q) * 33'd60 - 33'(ss_q);
			mi_n  = '0; ss_n = '0;
			if (hh_q == 5'd23) begin
				hh_n = '0; sod_n = '0;
				d_n = nd_d; m_n = nd_m; y_n = nd_y; wd_n = nd_wd;
			end else begin
				hh_n  = 5'(hh_q + 5'd1);
				sod_n = 17'(sod_q + 17'd3600 - 17'(mi_q) * 17'd60 - 17'(ss_q));
			end
		end else if (!min_ok) begin
			t_n  = t_q + 33'd60 - 33'(ss_q);
			ss_n = '0;
			if (mi_q == 6'd59) begin
				mi_n = '0;
				if (hh_q == 5'd23) begin
					hh_n = '0; sod_n = '0;
					d_n = nd_d; m_n = nd_m; y_n = nd_y; wd_n = nd_wd;
				end else begin
					hh_n  = 5'(hh_q + 5'd1);
					sod_n = 17'(sod_q + 17'd60 - 17'(ss_q));
				end
			end else begin
				mi_n  = 6'(mi_q + 6'd1);
				sod_n = 17'(sod_q + 17'd60 - 17'(ss_q));
			end
		end else if (!sec_ok) begin
			t_n = t_q + 33'd1;
			if (ss_q == 6'd59) begin
				ss_n = '0;
				if (mi_q == 6'd59) begin
					mi_n = '0;
					if (hh_q == 5'd23) begin
						hh_n = '0; sod_n = '0;
						d_n = nd_d; m_n = nd_m; y_n = nd_y; wd_n = nd_wd;
					end else begin
						hh_n  = 5'(hh_q + 5'd1);
						sod_n = 17'(sod_q + 17'd1);
					end
				end else begin
					mi_n  = 6'(mi_q + 6'd1);
					sod_n = 17'(sod_q + 17'd1);
				end
			end else begin
				ss_n  = 6'(ss_q + 6'd1);
				sod_n = 17'(sod_q + 17'd1);
			end
		end else begin
			hit = 1'b1;
		end
	end

	// status to controller
	assign sts.div_last = cnt_q;
	assign sts.hms_done = rem_q < 17'd60;
	assign sts.ymd_done = (quo_q < 16'(ylen)) && (quo_q < 16'(dim));
	assign sts.step_fin = hit || t_n[32] || step_last;

	// search registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q     <= {1'b0, start_time};
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= 1'b0;
			wd_q    <= '0;
			hh_q    <= '0;
			mi_q    <= '0;
			ss_q    <= '0;
			y_q     <= EPOCH_YEAR;
			m_q     <= 4'd1;
			step_q  <= '0;
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (cmd.div_en) begin
			cnt_q <= 1'b1;
			if (!cnt_q) begin
				quo_q <= recip_prod[50:35];
			end else begin
				rem_q <= sod_split;
				sod_q <= sod_split;
				wd_q  <= mod7(oct_sum);
			end
		end else if (cmd.hms_en) begin
			if (rem_q >= 17'd3600) begin
				rem_q <= 17'(rem_q - 17'd3600);
				hh_q  <= 5'(hh_q + 5'd1);
			end else if (rem_q >= 17'd60) begin
				rem_q <= 17'(rem_q - 17'd60);
				mi_q  <= 6'(mi_q + 6'd1);
			end else begin
				ss_q <= rem_q[5:0];
			end
		end else if (cmd.ymd_en) begin
			if (quo_q >= 16'(ylen)) begin
				quo_q <= 16'(quo_q - 16'(ylen));
				y_q   <= 12'(y_q + 12'd1);
			end else if (quo_q >= 16'(dim)) begin
				quo_q <= 16'(quo_q - 16'(dim));
				m_q   <= 4'(m_q + 4'd1);
			end else begin
				d_q <= 5'(quo_q[4:0] + 5'd1);
			end
		end else if (cmd.step_en) begin
			step_q <= SW'(step_q + 1'b1);
			if (hit) begin
				found_q <= 1'b1;
			end else begin
				t_q   <= t_n;
				sod_q <= sod_n;
				hh_q  <= hh_n;
				mi_q  <= mi_n;
				ss_q  <= ss_n;
				d_q   <= d_n;
				m_q   <= m_n;
				y_q   <= y_n;
				wd_q  <= wd_n;
				ovf_q <= t_n[32];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.wr_res) begin
			res_found_q <= found_q && !ovf_q;
			res_time_q  <= ovf_q ? 32'hFFFF_FFFF : t_q[31:0];
		end
	end

	assign found     = res_found_q;
	assign next_time = res_time_q;

endmodule

// ===== sv/cron_next_match_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cron_next_match_time
// Searches forward from a start time for the next time allowed by cron masks.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, start_time): one request per search.
//    in_ready is high only while no search is running.
//  - Output channel (out_valid/out_ready, found, next_time): one result per
//    request, held in an output register until taken.
//  - Config: cfg_we/cfg_index/cfg_data write one mask register per cycle;
//    write only while idle.
// Sequence per request: the day/second split (reciprocal multiply), then the
// hours/minutes/seconds split, then the walk over years and months, then the
// search steps (at most MAX_STEPS-1), then the result is loaded into the
// output register. The step count is data dependent.
// If the receiver stalls, a finished result waits in the search registers until
// the output register is free; in_ready stays low until it has moved there.
// Reset clears the sequencer, the output valid flag and sets all masks to ones.
// ----------------------------------------------------------------------------
module cron_next_match_time #(
	parameter int MAX_STEPS = 65535
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [cnmt_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [31:0]                 start_time,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [31:0]                 next_time
);
	import cnmt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cnmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cnmt_dp #(
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start_time (start_time),
		.cmd        (cmd),
		.sts        (sts),
		.found      (found),
		.next_time  (next_time)
	);

endmodule

// ===== sv/cnmt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnmt_checker
// Port-level checks for the cron next-match block, bound to the top level.
// ----------------------------------------------------------------------------
module cnmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [31:0] next_time
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(next_time))
		else $error("stalled result changed");

	// once a request is taken the block is busy for the time split
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request taken while a search runs");

	// reset empties the output register
	assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind cron_next_match_time cnmt_checker u_cnmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.found     (found),
	.next_time (next_time)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cron_next_match_time. A scoreboard keeps its own
// copy of the mask registers and works out each search result in zero time
// with a calendar predictor. Directed mask settings and start times come
// first, then random mask settings with random starts. Both channels idle at
// random, except in the random phases with no_idle set.
// ----------------------------------------------------------------------------
module testbench;
	import cnmt_pkg::*;

	localparam int          STEP_LIMIT = 65535;
	localparam logic [2:0]  IDX_SPARE0 = 3'd6;   // unused register indexes
	localparam logic [2:0]  IDX_SPARE1 = 3'd7;
	localparam logic [59:0] ONES60     = 60'hFFF_FFFF_FFFF_FFFF;

	typedef struct {
		bit          found;
		logic [31:0] next_time;
	} match_t;

	// Mask copy, match-time predictor and queue of pending search results
	class match_time_scoreboard;
		logic [59:0] sec_m, min_m;
		logic [23:0] hour_m;
		logic [30:0] day_m;
		logic [11:0] mon_m;
		logic [6:0]  wday_m;
		match_t      pending_q[$];
		int          fail_count;

		function new();
			sec_m = ONES60; min_m = ONES60; hour_m = '1;
			day_m = ALL_DAYS; mon_m = '1; wday_m = '1;
			fail_count = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [59:0] v);
			case (idx)
				REG_SECOND:  sec_m  = v;
				REG_MINUTE:  min_m  = v;
				REG_HOUR:    hour_m = v[23:0];
				REG_DAY:     day_m  = v[30:0];
				REG_MONTH:   mon_m  = v[11:0];
				REG_WEEKDAY: wday_m = v[6:0];
				default: ;
			endcase
		endfunction

		// civil calendar: day count since 1970 -> year/month/day, and year/month -> day count of the month's first day
		function void split_days(longint unsigned z, output longint unsigned y,
				output longint unsigned m, output longint unsigned d);
			longint unsigned zz, era, doe, yoe, doy, mp;
			zz  = z + 719468;
			era = zz / 146097;
			doe = zz - era * 146097;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp  = (5 * doy + 2) / 153;
			m   = (mp < 10) ? mp + 3 : mp - 9;
			d   = doy - (153 * mp + 2) / 5 + 1;
			y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
		endfunction

		function longint unsigned join_days(longint unsigned y, longint unsigned m);
			longint unsigned yy, era, yoe, doy, doe;
			yy  = y - ((m <= 2) ? 1 : 0);
			era = yy / 400;
			yoe = yy - era * 400;
			doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			return era * 146097 + doe - 719468;
		endfunction

		function match_t predict_match(logic [31:0] start);
			longint unsigned t, dn, sod, y, m, d, hh, mi, ss;
			bit     done, ovf, day_ok;
			match_t r;
			t = 64'(start); done = 0; ovf = 0;
			for (int step = 1; step < STEP_LIMIT && !done; step++) begin
				dn  = t / SEC_PER_DAY;
				sod = t % SEC_PER_DAY;
				split_days(dn, y, m, d);
				if (!mon_m[m-1]) begin
					// month not allowed: first of next month
					if (m == 12) begin
						y = y + 1; m = 1;
					end else
						m = m + 1;
					t = join_days(y, m) * SEC_PER_DAY;
				end else begin
					if (day_m != ALL_DAYS)
						day_ok = day_m[d-1];
					else
						day_ok = wday_m[(dn + EPOCH_WDAY) % 7];
					if (!day_ok)
						t = (dn + 1) * SEC_PER_DAY;
					else begin
						hh = sod / 3600;
						mi = (sod / 60) % 60;
						ss = sod % 60;
						if (!hour_m[hh])
							t = t + 3600 - mi * 60 - ss;
						else if (!min_m[mi])
							t = t + 60 - ss;
						else if (!sec_m[ss])
							t = t + 1;
						else
							done = 1;
					end
				end
				if (t > 64'hFFFF_FFFF) begin
					ovf = 1;
					break;
				end
			end
			r.found     = ovf ? 1'b0 : done;
			r.next_time = ovf ? 32'hFFFF_FFFF : t[31:0];
			return r;
		endfunction

		function void note_request(logic [31:0] start);
			pending_q.push_back(predict_match(start));
		endfunction

		function void check_result(logic fnd, logic [31:0] nt);
			match_t e;
			if (pending_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result found=%0b next_time=%0d", fnd, nt);
				return;
			end
			e = pending_q.pop_front();
			if (fnd !== e.found || nt !== e.next_time) begin
				fail_count++;
				if (fail_count <= 10)
					$display("mismatch: expected found=%0b next_time=%0d, got found=%0b next_time=%0d",
						e.found, e.next_time, fnd, nt);
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [59:0] cfg_data;
	logic        in_valid, in_ready;
	logic [31:0] start_time;
	logic        out_valid, out_ready;
	logic        found;
	logic [31:0] next_time;
	bit          no_idle;

	match_time_scoreboard sb = new();

	cron_next_match_time u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .start_time(start_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .next_time(next_time)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard limit on run time
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// monitors: accepted requests and results, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_request(start_time);
		if (arst_n && out_valid && out_ready)
			sb.check_result(found, next_time);
	end

	// result side: random stalls before each result
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// one request; called and returns at a falling edge
	task automatic send_request(logic [31:0] st);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		start_time <= st;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// hold off requests until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [59:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// random mask of w bits, never zero; dense, sparse or full
	function automatic logic [59:0] rand_mask(int w);
		logic [59:0] v, lim;
		lim = ONES60 >> (60 - w);
		case ($urandom_range(0, 2))
			0: v = lim;
			1: v = 60'({$urandom, $urandom}) & lim;
			default: v = 60'({$urandom, $urandom}) & 60'({$urandom, $urandom})
			           & 60'({$urandom, $urandom}) & lim;
		endcase
		if (v == 0)
			v[$urandom_range(0, w - 1)] = 1'b1;
		return v;
	endfunction

	function automatic logic [31:0] rand_start();
		case ($urandom_range(0, 5))
			0: return 32'hFFFF_FFFF - $urandom_range(0, 4000000);
			1: return $urandom_range(0, 100000000);
			default: return $urandom;
		endcase
	endfunction

	// stimulus
	initial begin
		logic [59:0] dm;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_SECOND;
		cfg_data   = '0;
		in_valid   = 1'b0;
		start_time = '0;
		no_idle    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset masks: every start matches at once
		send_request(32'h0000_0000);
		send_request(32'hFFFF_FFFF);
		send_request(32'h7FFF_FFFF);
		send_request(32'h8000_0000);
		send_request(32'd951782400);            // leap day 2000
		drain();

		// Sundays at midnight only, weekday decides; junk above register widths
		write_reg(REG_SECOND, 60'h1);
		write_reg(REG_MINUTE, 60'h1);
		write_reg(REG_HOUR, {36'hABC_DEF0_1, 24'h1});
		write_reg(REG_DAY, {29'h1555_5555, ALL_DAYS});
		write_reg(REG_WEEKDAY, {53'h1F_FFFF_FFFF_FFFF, 7'h01});
		send_request(32'h0000_0000);
		send_request(32'd1234567890);
		send_request(32'hFFFF_FF00);             // next Sunday lies past 32 bits
		drain();

		// leap day only, day mask decides; spare indexes are ignored
		write_reg(REG_SECOND, ONES60);
		write_reg(REG_MINUTE, ONES60);
		write_reg(REG_HOUR, ONES60);
		write_reg(REG_DAY, 60'h1000_0000);
		write_reg(REG_MONTH, {48'hFFFF_FFFF_FFFF, 12'h002});
		write_reg(IDX_SPARE0, 60'h0);
		write_reg(IDX_SPARE1, 60'h0);
		send_request(32'h0000_0000);
		send_request(32'd4102444800);            // 2100 is not a leap year
		send_request(32'hFFFF_FFFF);
		drain();

		// step limit: no second allowed
		write_reg(REG_DAY, 60'(ALL_DAYS));
		write_reg(REG_MONTH, 60'hFFF);
		write_reg(REG_WEEKDAY, 60'h7F);
		write_reg(REG_SECOND, 60'h0);
		send_request(32'd1000);
		drain();
		// no month allowed: runs past 32 bits
		write_reg(REG_SECOND, ONES60);
		write_reg(REG_MONTH, 60'h0);
		send_request(32'h0000_0000);
		drain();
		// hours, minutes and days each empty on their own
		write_reg(REG_MONTH, 60'hFFF);
		write_reg(REG_HOUR, 60'h0);
		send_request(32'hFFFF_0000);
		drain();
		write_reg(REG_HOUR, ONES60);
		write_reg(REG_MINUTE, 60'h0);
		send_request(32'hFFFF_F000);
		drain();
		write_reg(REG_MINUTE, ONES60);
		write_reg(REG_DAY, 60'h0);
		send_request(32'hFFF0_0000);
		drain();

		// random mask settings, about 120 requests
		for (int ph = 0; ph < 8; ph++) begin
			no_idle = (ph % 3 == 2);
			write_reg(REG_SECOND, rand_mask(60));
			write_reg(REG_MINUTE, rand_mask(60));
			write_reg(REG_HOUR, rand_mask(24) | 60'({$urandom, $urandom} << 24));
			// keep a day at or below the 28th so every allowed month has one
			dm = ($urandom_range(0, 2) == 0) ? 60'(ALL_DAYS)
			   : (60'({$urandom, $urandom}) & 60'(ALL_DAYS));
			dm[$urandom_range(0, 27)] = 1'b1;
			write_reg(REG_DAY, dm | 60'({$urandom, $urandom} << 31));
			write_reg(REG_MONTH, rand_mask(12) | 60'({$urandom, $urandom} << 12));
			write_reg(REG_WEEKDAY, rand_mask(7) | 60'({$urandom, $urandom} << 7));
			for (int k = 0; k < 15; k++) begin
				if ($urandom_range(0, 11) == 0)
					drain();
				send_request(rand_start());
			end
			drain();
		end

		no_idle = 1'b0;
		drain();
		repeat (50) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cnmt_pkg.sv
sv/cnmt_ctrl.sv
sv/cnmt_dp.sv
sv/cron_next_match_time.sv
sv/cnmt_checker.sv
tb/sv/testbench.sv
